/* rtl/core/stfc_pkg.sv */
// Shared types and constants for the sparse tensor fiber counter.
// Used by every module under rtl/core; depends on nothing.
package stfc_pkg;

    localparam int COORD_W          = 32;   // width of one coordinate on the bus
    localparam int OUT_W            = 32;   // width of one result field on the bus
    localparam int FIELD_MODES      = 4;    // coordinates carried per tuple
    localparam int FIELD_LEVELS     = 3;    // levels that can be compared
    localparam int MAX_MODES        = 4;    // largest mode count the block honors
    localparam int MODES_HI         = (MAX_MODES < FIELD_MODES) ? MAX_MODES : FIELD_MODES;
    localparam int MODES_LO         = 2;
    localparam int INDEX_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF  = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam int NM_W             = 3;    // num_modes register width
    localparam int MODE_W           = 2;    // order register width
    localparam int LVL_W            = 2;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 3;

    localparam logic [NM_W-1:0] NUM_MODES_RST = NM_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_MODES = 3'd0,
        REG_ORDER_0   = 3'd1,
        REG_ORDER_1   = 3'd2,
        REG_ORDER_2   = 3'd3,
        REG_ORDER_3   = 3'd4
    } t_cfg_reg;

    typedef enum logic [LVL_W-1:0] {
        LVL_0 = 2'd0,
        LVL_1 = 2'd1,
        LVL_2 = 2'd2
    } t_level;

    // Settings seen by the front end for each tuple
    typedef struct packed {
        logic [NM_W-1:0]                     nm;     // clamped mode count
        logic [FIELD_LEVELS-1:0][MODE_W-1:0] order;  // mode compared per level
    } t_stfc_cfg;

    // Classified tuple handed from front to back
    typedef struct packed {
        logic            inc;    // some level counter advances
        t_level          level;  // which one
        logic            last;   // closes the tensor
        logic [NM_W-1:0] nm;     // mode count in force for this tuple
    } t_stfc_cmd;

    typedef struct packed {
        logic [OUT_W-1:0] fiber_total;
        logic [OUT_W-1:0] level_count_2;
        logic [OUT_W-1:0] level_count_1;
        logic [OUT_W-1:0] level_count_0;
    } t_stfc_result;

endpackage

/* rtl/core/stfc_front.sv */
// Front end: accepts coordinate tuples, compares them with the previous tuple
// and classifies each into a level increment. Depends on stfc_pkg.
module stfc_front
    import stfc_pkg::*;
#(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_stfc_cfg                           i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [FIELD_MODES-1:0][COORD_W-1:0] i_coord,
    input  logic                                i_last,
    input  logic                                i_q_ready,
    output logic                                o_push,
    output t_stfc_cmd                           o_cmd
);

    localparam int IDX_W = (INDEX_WIDTH < COORD_W) ? INDEX_WIDTH : COORD_W;

    logic [IDX_W-1:0]        r_prev [FIELD_MODES];
    logic                    r_have_prev;
    logic [FIELD_LEVELS-1:0] diff;
    logic [FIELD_LEVELS-1:0] en;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    always_comb begin
        for (int l = 0; l < FIELD_LEVELS; l++) begin
            diff[l] = i_coord[i_cfg.order[l]][IDX_W-1:0] != r_prev[i_cfg.order[l]];
            en[l]   = (NM_W'(l) + NM_W'(1)) < i_cfg.nm;
        end
    end

    always_comb begin
        o_cmd.inc   = 1'b0;
        o_cmd.level = LVL_0;
        o_cmd.last  = i_last;
        o_cmd.nm    = i_cfg.nm;
        if (!r_have_prev) begin
            // first tuple of a tensor opens a new top-level prefix
            o_cmd.inc = 1'b1;
        end else begin
            // walk from the deepest level so the shallowest difference wins
            for (int l = FIELD_LEVELS - 1; l >= 0; l--) begin
                if (en[l] && diff[l]) begin
                    o_cmd.inc   = 1'b1;
                    o_cmd.level = t_level'(LVL_W'(l));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            for (int m = 0; m < FIELD_MODES; m++) begin
                r_prev[m] <= i_coord[m][IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (o_push) begin
            r_have_prev <= !i_last;
        end
    end

endmodule

/* rtl/core/stfc_queue.sv */
// Short command queue between the front and back ends of the fiber counter.
// Depends on stfc_pkg.
module stfc_queue
    import stfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_stfc_cmd i_cmd,
    output logic      o_ready,
    output logic      o_valid,
    output t_stfc_cmd o_cmd,
    input  logic      i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_stfc_cmd        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_ready = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/core/stfc_back.sv */
// Back end: applies classified tuples to the level and fiber counters and,
// at the end of a tensor, forms the prefix sums in a short result pipeline.
// Depends on stfc_pkg.
module stfc_back
    import stfc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_stfc_cmd    i_cmd,
    output logic         o_pop,
    output logic         o_valid,
    input  logic         i_ready,
    output t_stfc_result o_result
);

    localparam int CNT_W = COUNT_WIDTH;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
        return (&a) ? a : a + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [CNT_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_W-1:0];
    endfunction

    // counting stage
    logic [CNT_W-1:0] r_cnt [FIELD_LEVELS];
    logic [CNT_W-1:0] r_fib;
    logic [CNT_W-1:0] n_cnt [FIELD_LEVELS];
    logic [CNT_W-1:0] n_fib;

    // snapshot stage
    logic             r_b_valid;
    logic [CNT_W-1:0] r_b_cnt [FIELD_LEVELS];
    logic [CNT_W-1:0] r_b_fib;
    logic [NM_W-1:0]  r_b_nm;

    // first partial sum stage
    logic             r_c_valid;
    logic [CNT_W-1:0] r_c_p0;
    logic [CNT_W-1:0] r_c_p1;
    logic [CNT_W-1:0] r_c_c2;
    logic [CNT_W-1:0] r_c_fib;
    logic [NM_W-1:0]  r_c_nm;

    // output register
    logic             r_o_valid;
    t_stfc_result     r_o_result;

    logic out_ready;
    logic c_ready;
    logic b_ready;

    assign out_ready = !r_o_valid || i_ready;
    assign c_ready   = !r_c_valid || out_ready;
    assign b_ready   = !r_b_valid || c_ready;
    // a closing tuple waits until the snapshot stage can take it
    assign o_pop     = i_q_valid && (!i_cmd.last || b_ready);

    assign o_valid  = r_o_valid;
    assign o_result = r_o_result;

    always_comb begin
        for (int l = 0; l < FIELD_LEVELS; l++) begin
            n_cnt[l] = (i_cmd.inc && i_cmd.level == t_level'(LVL_W'(l))) ?
                       sat_inc(r_cnt[l]) : r_cnt[l];
        end
        n_fib = i_cmd.inc ? sat_inc(r_fib) : r_fib;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < FIELD_LEVELS; l++) begin
                r_cnt[l] <= '0;
            end
            r_fib <= '0;
        end else if (o_pop) begin
            for (int l = 0; l < FIELD_LEVELS; l++) begin
                r_cnt[l] <= i_cmd.last ? '0 : n_cnt[l];
            end
            r_fib <= i_cmd.last ? '0 : n_fib;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (b_ready) begin
                r_b_valid <= o_pop && i_cmd.last;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && o_pop && i_cmd.last) begin
            for (int l = 0; l < FIELD_LEVELS; l++) begin
                r_b_cnt[l] <= n_cnt[l];
            end
            r_b_fib <= n_fib;
            r_b_nm  <= i_cmd.nm;
        end
        if (c_ready && r_b_valid) begin
            r_c_p0  <= r_b_cnt[0];
            r_c_p1  <= sat_add(r_b_cnt[0], r_b_cnt[1]);
            r_c_c2  <= r_b_cnt[2];
            r_c_fib <= r_b_fib;
            r_c_nm  <= r_b_nm;
        end
        if (out_ready && r_c_valid) begin
            // levels at or above num_modes-1 read zero
            r_o_result.level_count_0 <= to_out(r_c_p0);
            r_o_result.level_count_1 <= (r_c_nm >= NM_W'(3)) ? to_out(r_c_p1) : '0;
            r_o_result.level_count_2 <= (r_c_nm >= NM_W'(4)) ?
                                        to_out(sat_add(r_c_p1, r_c_c2)) : '0;
            r_o_result.fiber_total   <= to_out(r_c_fib);
        end
    end

endmodule

/* rtl/core/sparse_tensor_fiber_counter.sv */
// Sparse tensor fiber counter: counts distinct index prefixes per level of a
// sorted stream of nonzero coordinate tuples.
//
// Input stream (i_s_*): one tuple per transaction, coordinates of modes 0..3
// in tdata, tlast on the final nonzero of a tensor. Output stream (o_m_*):
// one transaction per tensor, issued for the tuple carrying tlast, with the
// per-level prefix counts and the fiber total. Configuration channel
// (i_cfg_*): register 0 is num_modes, registers 1..4 are order_0..order_3;
// write it only while the block is idle.
//
// Throughput: one tuple per cycle while tready is high, set by the combinational
// compare and priority select in the front end and one counter update per cycle
// in the back end. A closing tuple passes the command queue, snapshot stage,
// first partial sum stage and output register before the result is valid. A stalled
// receiver holds the result; tuples keep flowing until the two-entry queue and
// the result pipeline fill, then tready drops. Reset restores num_modes = 3,
// order = 0,1,2 and clears all counters; tuples are accepted straight after reset.
// Depends on stfc_pkg, stfc_front, stfc_queue and stfc_back.
module sparse_tensor_fiber_counter
    import stfc_pkg::*;
#(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]             i_cfg_data,
    // tuple stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [FIELD_MODES*COORD_W-1:0]    i_s_tdata,  // coord_0, coord_1, coord_2, coord_3
    input  logic                              i_s_tlast,  // last_item
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [4*OUT_W-1:0]                o_m_tdata   // level_count_0, level_count_1,
                                                          // level_count_2, fiber_total
);

    logic [NM_W-1:0]                     r_num_modes;
    logic [FIELD_LEVELS-1:0][MODE_W-1:0] r_order;
    logic [NM_W-1:0]                     nm_eff;
    t_stfc_cfg                           cfg;

    logic [FIELD_MODES-1:0][COORD_W-1:0] coord;
    logic                                q_push;
    logic                                q_ready;
    logic                                q_valid;
    logic                                q_pop;
    t_stfc_cmd                           push_cmd;
    t_stfc_cmd                           head_cmd;
    t_stfc_result                        result;

    assign o_cfg_ready = 1'b1;

    // order_3 names the uncompared last level: its write is accepted and dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_modes <= NUM_MODES_RST;
            for (int l = 0; l < FIELD_LEVELS; l++) begin
                r_order[l] <= MODE_W'(l);
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_NUM_MODES: r_num_modes <= i_cfg_data[NM_W-1:0];
                REG_ORDER_0:   r_order[0]  <= i_cfg_data[MODE_W-1:0];
                REG_ORDER_1:   r_order[1]  <= i_cfg_data[MODE_W-1:0];
                REG_ORDER_2:   r_order[2]  <= i_cfg_data[MODE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        nm_eff = r_num_modes;
        if (r_num_modes < NM_W'(MODES_LO)) begin
            nm_eff = NM_W'(MODES_LO);
        end else if (r_num_modes > NM_W'(MODES_HI)) begin
            nm_eff = NM_W'(MODES_HI);
        end
    end

    assign cfg.nm    = nm_eff;
    assign cfg.order = r_order;
    assign coord     = i_s_tdata;

    stfc_front #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_coord   (coord),
        .i_last    (i_s_tlast),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_cmd     (push_cmd)
    );

    stfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (q_pop)
    );

    stfc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_result  (result)
    );

    assign o_m_tdata = result;

`ifndef NO_ASSERTIONS
    // a full queue always has a head to drain
    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_ready |-> q_valid)
        else $error("queue full without a valid head");

    // clamped mode count stays in the supported range
    a_nm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nm_eff >= NM_W'(MODES_LO) && nm_eff <= NM_W'(MODES_HI))
        else $error("effective mode count out of range");

    // the tuple after a closing tuple opens a new tensor at level zero
    a_new_tensor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(q_push && i_s_tlast) && q_push) |-> (push_cmd.inc && push_cmd.level == LVL_0))
        else $error("first tuple of a tensor not counted at level zero");
`endif

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for sparse_tensor_fiber_counter: streams coordinate tuples
// and checks each result against a predictor kept in a small scoreboard class.
// Depends on stfc_pkg and the block's RTL.
import stfc_pkg::*;

class stfc_scoreboard;
    logic [NM_W-1:0]    num_modes;
    logic [MODE_W-1:0]  order [FIELD_MODES];
    logic [COORD_W-1:0] prev_coord [FIELD_MODES];
    bit                 have_prev;
    logic [OUT_W-1:0]   level_incs [FIELD_LEVELS];
    logic [OUT_W-1:0]   fiber_tally;
    t_stfc_result       pending [$];
    int                 errors;
    int                 tuples;
    int                 tensors;

    function new();
        num_modes = NUM_MODES_RST;
        for (int m = 0; m < FIELD_MODES; m++) begin
            order[m]      = MODE_W'(m);
            prev_coord[m] = '0;
        end
        clear_tensor();
        errors  = 0;
        tuples  = 0;
        tensors = 0;
    endfunction

    function void clear_tensor();
        have_prev = 0;
        for (int l = 0; l < FIELD_LEVELS; l++) level_incs[l] = '0;
        fiber_tally = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (idx == REG_NUM_MODES)
            num_modes = val;
        else if (idx >= REG_ORDER_0 && idx <= REG_ORDER_3)
            order[idx - REG_ORDER_0] = val[MODE_W-1:0];
    endfunction

    function int modes_in_use();
        int n;
        n = num_modes;
        if (n < MODES_LO) n = MODES_LO;
        if (n > MODES_HI) n = MODES_HI;
        return n;
    endfunction

    function logic [OUT_W-1:0] sat_sum(logic [OUT_W-1:0] a, logic [OUT_W-1:0] b);
        logic [OUT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[OUT_W] ? '1 : s[OUT_W-1:0];
    endfunction

    // Classify one accepted tuple; queue a result when it closes the tensor.
    function void note_tuple(logic [FIELD_MODES*COORD_W-1:0] data, logic last);
        logic [COORD_W-1:0] cur [FIELD_MODES];
        logic [OUT_W-1:0]   run;
        logic [OUT_W-1:0]   cnt [FIELD_LEVELS];
        t_stfc_result       res;
        int                 nm;
        bit                 hit;
        nm  = modes_in_use();
        hit = 0;
        tuples++;
        for (int m = 0; m < FIELD_MODES; m++) cur[m] = data[m*COORD_W +: COORD_W];
        if (!have_prev) begin
            level_incs[0] = sat_sum(level_incs[0], 1);
            fiber_tally   = sat_sum(fiber_tally, 1);
        end else begin
            for (int l = 0; l + 1 < nm && !hit; l++) begin
                if (cur[order[l]] != prev_coord[order[l]]) begin
                    level_incs[l] = sat_sum(level_incs[l], 1);
                    fiber_tally   = sat_sum(fiber_tally, 1);
                    hit = 1;
                end
            end
        end
        for (int m = 0; m < FIELD_MODES; m++) prev_coord[m] = cur[m];
        have_prev = 1;
        if (!last) return;
        run = '0;
        for (int l = 0; l < FIELD_LEVELS; l++) begin
            if (l + 1 < nm) begin
                run    = sat_sum(run, level_incs[l]);
                cnt[l] = run;
            end else begin
                cnt[l] = '0;
            end
        end
        res.level_count_0 = cnt[0];
        res.level_count_1 = cnt[1];
        res.level_count_2 = cnt[2];
        res.fiber_total   = fiber_tally;
        pending.push_back(res);
        clear_tensor();
    endfunction

    function void compare_field(string field, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic [4*OUT_W-1:0] data);
        t_stfc_result got;
        t_stfc_result want;
        got = data;
        tensors++;
        if (pending.size() == 0) begin
            $error("result with nothing expected: %h", data);
            errors++;
            return;
        end
        want = pending.pop_front();
        compare_field("level_count_0", want.level_count_0, got.level_count_0);
        compare_field("level_count_1", want.level_count_1, got.level_count_1);
        compare_field("level_count_2", want.level_count_2, got.level_count_2);
        compare_field("fiber_total", want.fiber_total, got.fiber_total);
    endfunction
endclass

module tb_top;
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [CFG_IDX_W-1:0]           i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]          i_cfg_data  = '0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [FIELD_MODES*COORD_W-1:0] i_s_tdata   = '0;
    logic                           i_s_tlast   = 1'b0;
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [4*OUT_W-1:0]             o_m_tdata;

    stfc_scoreboard sb = new();

    int               send_idle_pct = 0;
    int               rx_stall_pct  = 0;
    int               settings_used = 1;
    logic [COORD_W-1:0] gen_coord [FIELD_MODES] = '{default: '0};
    logic [NM_W-1:0]  nm_plan [8] = '{3'd2, 3'd4, 3'd0, 3'd7, 3'd1, 3'd5, 3'd3, 3'd6};

    sparse_tensor_fiber_counter dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) i_m_tready <= ($urandom_range(99) >= rx_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            if (i_s_tvalid && o_s_tready) sb.note_tuple(i_s_tdata, i_s_tlast);
        end
    end

    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [FIELD_MODES*COORD_W-1:0] pack4(
        logic [COORD_W-1:0] c0, logic [COORD_W-1:0] c1,
        logic [COORD_W-1:0] c2, logic [COORD_W-1:0] c3);
        return {c3, c2, c1, c0};
    endfunction

    // Mostly tiny indexes so prefixes repeat; now and then the top of the range.
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(9))
            0:       return 32'hFFFF_FFFF - $urandom_range(2);
            1:       return $urandom();
            default: return $urandom_range(3);
        endcase
    endfunction

    // Keep tvalid high across back-to-back transactions; drop it only for a gap.
    task automatic send_tuple(input logic [FIELD_MODES*COORD_W-1:0] data, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // Hold off until every result is in, then let the pipeline settle.
    // Wait on the clock first so the monitor has logged the final tuple.
    task automatic pause();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic configure(input int p);
        cfg_write(REG_NUM_MODES, nm_plan[p]);
        for (int k = 0; k < FIELD_MODES; k++)
            cfg_write(CFG_IDX_W'(REG_ORDER_0 + k),
                      (p == 1) ? CFG_DATA_W'(3 - k) : CFG_DATA_W'($urandom_range(7)));
        // unmapped index: must be dropped
        cfg_write(CFG_IDX_W'(REG_ORDER_3 + 1 + $urandom_range(2)), CFG_DATA_W'($urandom_range(7)));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Sorted-looking: keep random leading levels, vary the rest; noisy varies all.
    task automatic run_tensor(input int len, input bit noisy);
        int keep;
        bit kept;
        for (int i = 0; i < len; i++) begin
            keep = $urandom_range(FIELD_MODES);
            for (int m = 0; m < FIELD_MODES; m++) begin
                kept = 0;
                for (int l = 0; l < keep; l++)
                    if (sb.order[l] == m) kept = 1;
                if (noisy)
                    gen_coord[m] = $urandom();
                else if (!kept && $urandom_range(1))
                    gen_coord[m] = pick_coord();
            end
            send_tuple(pack4(gen_coord[0], gen_coord[1], gen_coord[2], gen_coord[3]),
                       i == len - 1);
        end
    endtask

    task automatic directed_tuples();
        // lone tuple opens and closes a tensor
        send_tuple(pack4(0, 0, 0, 0), 1'b1);
        send_tuple(pack4('1, '1, '1, '1), 1'b0);
        send_tuple(pack4('1, '1, '1, '1), 1'b0);
        send_tuple(pack4(0, '1, '1, '1), 1'b0);
        send_tuple(pack4(0, 0, '1, '1), 1'b0);
        // mode two sits at level two, not compared with three modes
        send_tuple(pack4(0, 0, 0, '1), 1'b0);
        send_tuple(pack4(0, 0, 0, 0), 1'b0);
        send_tuple(pack4(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA), 1'b0);
        send_tuple(pack4(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555), 1'b1);
        // first tuple of a tensor equal to the previous one still counts
        send_tuple(pack4(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555), 1'b0);
        send_tuple(pack4(32'hAAAA_AAAA, 32'h5555_5556, 32'hAAAA_AAAA, 32'h5555_5555), 1'b0);
        send_tuple(pack4(32'hAAAA_AAAB, 32'h5555_5556, 32'hAAAA_AAAA, 32'h5555_5555), 1'b1);
    endtask

    initial begin
        int phase_tuples;
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_tuples();
        pause();
        for (int p = 0; p < 8; p++) begin
            configure(p);
            case (p % 4)
                0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin send_idle_pct = 80; rx_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rx_stall_pct = 80; end
                default: begin send_idle_pct = 18; rx_stall_pct = 18; end
            endcase
            phase_tuples = 0;
            while (phase_tuples < 124) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                run_tensor(len, $urandom_range(7) == 0);
                phase_tuples += len;
            end
            pause();
        end
        $display("Checked %0d tensors built from %0d tuples", sb.tensors, sb.tuples);
        $display("across %0d register settings and four idle patterns", settings_used);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* files.f */
rtl/core/stfc_pkg.sv
rtl/core/stfc_front.sv
rtl/core/stfc_queue.sv
rtl/core/stfc_back.sv
rtl/core/sparse_tensor_fiber_counter.sv
verif/tb_top.sv
